// File: src/fpamu_pkg.sv
// fpamu_pkg: shared constants, types and helpers for the fixed-point affine matrix unit
// no dependencies
`timescale 1ns / 1ps

package fpamu_pkg;

   localparam int unsigned UNIT_ONE = 65536;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned XformShift = 12;
   localparam int unsigned PostBase = 16;
   localparam int unsigned PreRot = 2;
   localparam int unsigned PreWide = 6;

   typedef logic signed [WordWidth-1:0] word_type;
   typedef logic [3:0] elem_idx_type;

   typedef enum logic [2:0] {
      ACT_WRITE_CUR = 3'd0,
      ACT_WRITE_OPD = 3'd1,
      ACT_IDENTITY  = 3'd2,
      ACT_TRANSLATE = 3'd3,
      ACT_CONCAT    = 3'd4,
      ACT_TRANSFORM = 3'd5
   } action_type;

   // request to the shared multiply-accumulate unit
   typedef struct packed {
      logic     clear;   // start a new sum with this term
      logic     mul_en;  // add product, else add term_a unchanged
      word_type term_a;
      word_type term_b;
      logic [4:0] post_shift;
   } mac_op_type;

   function automatic word_type identity_entry(input elem_idx_type idx);
      word_type r;
      r = '0;
      if (idx[1:0] == idx[3:2]) begin
         r = word_type'(UNIT_ONE);
      end
      return r;
   endfunction

endpackage

// File: src/fpamu_mac.sv
// fpamu_mac: shared 32x32 multiply with post shift and wrapping accumulator
// depends on fpamu_pkg
`timescale 1ns / 1ps

module fpamu_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   input  fpamu_pkg::mac_op_type op,
   output fpamu_pkg::word_type  acc
);

   // stage 1: product register
   fpamu_pkg::word_type prod_ff, prod_in;
   logic                vld_ff, vld_in;
   logic                clr_ff, clr_in;
   logic [4:0]          sh_ff, sh_in;
   fpamu_pkg::word_type acc_ff, acc_in;
   logic [63:0]         full_prod;
   fpamu_pkg::word_type shifted;

   assign full_prod = {32'd0, op.term_a} * {32'd0, op.term_b};

   always_comb begin
      prod_in = op.mul_en ? fpamu_pkg::word_type'(full_prod[31:0]) : op.term_a;
      vld_in  = op_valid;
      clr_in  = op.clear;
      sh_in   = op.mul_en ? op.post_shift : 5'd0;
   end

   assign shifted = prod_ff >>> sh_ff;

   always_comb begin
      acc_in = acc_ff;
      if (vld_ff) begin
         acc_in = clr_ff ? shifted : acc_ff + shifted;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      clr_ff  <= clr_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: src/fixed_point_affine_matrix_unit_core.sv
// fixed_point_affine_matrix_unit_core: top level, matrix storage and sequencer
// depends on fpamu_pkg and fpamu_mac
//
// channel | dir | fields
// req_    | in  | tuser: action[2:0]; tdata: index[3:0] value[35:4] x[67:36] y[99:68] z[131:100]
// rsp_    | out | tdata: out_x[31:0] out_y[63:32] out_z[95:64]
//
// writes, identity, translate and unknown actions complete while idle and can follow back to back
// transform is busy after its transfer for 3 rows, each with one mac issue per term, a drain and
// a store, and then hands the vertex to the output register; concatenate is busy for 16 entries,
// each with one mac issue per term, a drain and a store
// reset is synchronous and restores the identity matrix at once
// req_tready is low while an item is in work; a held result stalls only the next handoff
`timescale 1ns / 1ps

module fixed_point_affine_matrix_unit_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // action
   input  logic [135:0] req_tdata,   // index, value, coord_x, coord_y, coord_z, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata    // out_x, out_y, out_z
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_STORE = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   fpamu_pkg::word_type cur_ff [16];
   fpamu_pkg::word_type opd_ff [16];
   fpamu_pkg::word_type res_ff [16];
   fpamu_pkg::word_type vec_ff [3];
   fpamu_pkg::word_type outv_ff [3];
   logic                concat_ff, concat_in;
   logic [3:0]          ent_ff, ent_in;   // result entry (concat) or row
   logic [1:0]          k_ff, k_in;       // term within a sum
   logic [1:0]          dr_ff, dr_in;     // drain counter
   logic                rsp_valid_ff, rsp_valid_in;
   logic [95:0]         rsp_data_ff, rsp_data_in;

   fpamu_pkg::action_type act;
   fpamu_pkg::mac_op_type op;
   logic                  op_valid;
   fpamu_pkg::word_type   acc;
   logic [1:0]            row, col;
   logic [2:0]            sa, sb;
   fpamu_pkg::word_type   ca, ob;

   assign act = fpamu_pkg::action_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign row = ent_ff[3:2];
   assign col = ent_ff[1:0];

   always_comb begin
      sa = 3'(fpamu_pkg::PreRot);
      sb = 3'(fpamu_pkg::PreRot);
      if (row == 2'd3) begin
         sa = 3'(fpamu_pkg::PreWide);
         sb = 3'(fpamu_pkg::PreWide);
      end else if (col == 2'd3) begin
         sb = 3'(fpamu_pkg::PreWide);
      end
   end

   assign ca = cur_ff[{row, k_ff}] >>> sa;
   assign ob = opd_ff[{k_ff, col}] >>> sb;

   always_comb begin
      op = '0;
      op_valid = (state_ff == ST_ISSUE);
      op.clear = (k_ff == 2'd0);
      if (concat_ff) begin
         op.mul_en = 1'b1;
         op.term_a = ca;
         op.term_b = ob;
         op.post_shift = 5'(fpamu_pkg::PostBase) - 5'(sa) - 5'(sb);
      end else if (k_ff == 2'd3) begin
         op.mul_en = 1'b0;
         op.term_a = cur_ff[{row, 2'd3}];
      end else begin
         op.mul_en = 1'b1;
         op.term_a = vec_ff[k_ff];
         op.term_b = cur_ff[{row, k_ff}];
      end
   end

   fpamu_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op       (op),
      .acc      (acc)
   );

   always_comb begin
      state_in     = state_ff;
      concat_in    = concat_ff;
      ent_in       = ent_ff;
      k_in         = k_ff;
      dr_in        = dr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (act == fpamu_pkg::ACT_CONCAT ||
                               act == fpamu_pkg::ACT_TRANSFORM)) begin
               state_in  = ST_ISSUE;
               concat_in = (act == fpamu_pkg::ACT_CONCAT);
               ent_in    = '0;
               k_in      = '0;
            end
         end
         ST_ISSUE: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = ST_DRAIN;
               dr_in    = '0;
            end
         end
         ST_DRAIN: begin
            dr_in = dr_ff + 2'd1;
            if (dr_ff == 2'd1) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            state_in = ST_ISSUE;
            ent_in   = concat_ff ? ent_ff + 4'd1 : ent_ff + 4'd4;
            if (concat_ff ? (ent_ff == 4'd15) : (ent_ff == 4'd8)) begin
               state_in = concat_ff ? ST_IDLE : ST_OUT;
            end
         end
         ST_OUT: begin
            // hand the vertex over once the output register is free or draining
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {outv_ff[2], outv_ff[1], outv_ff[0]};
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         concat_ff    <= 1'b0;
         ent_ff       <= '0;
         k_ff         <= '0;
         dr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            cur_ff[i] <= fpamu_pkg::identity_entry(4'(i));
         end
      end else begin
         state_ff     <= state_in;
         concat_ff    <= concat_in;
         ent_ff       <= ent_in;
         k_ff         <= k_in;
         dr_ff        <= dr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_IDLE && req_tvalid) begin
            case (act)
               fpamu_pkg::ACT_WRITE_CUR: cur_ff[req_tdata[3:0]] <= req_tdata[35:4];
               fpamu_pkg::ACT_IDENTITY: begin
                  for (int i = 0; i < 16; i++) begin
                     cur_ff[i] <= fpamu_pkg::identity_entry(4'(i));
                  end
               end
               fpamu_pkg::ACT_TRANSLATE: begin
                  cur_ff[3]  <= cur_ff[3]  + req_tdata[67:36];
                  cur_ff[7]  <= cur_ff[7]  + req_tdata[99:68];
                  cur_ff[11] <= cur_ff[11] + req_tdata[131:100];
               end
               default: ;
            endcase
         end
         // whole concatenation result lands at once
         if (state_ff == ST_STORE && concat_ff && ent_ff == 4'd15) begin
            for (int i = 0; i < 15; i++) begin
               cur_ff[i] <= res_ff[i];
            end
            cur_ff[15] <= acc;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_IDLE && req_tvalid && act == fpamu_pkg::ACT_WRITE_OPD) begin
         opd_ff[req_tdata[3:0]] <= req_tdata[35:4];
      end
      if (state_ff == ST_IDLE && req_tvalid) begin
         vec_ff[0] <= req_tdata[67:36];
         vec_ff[1] <= req_tdata[99:68];
         vec_ff[2] <= req_tdata[131:100];
      end
      if (state_ff == ST_STORE) begin
         if (concat_ff) begin
            res_ff[ent_ff] <= acc;
         end else begin
            outv_ff[ent_ff[3:2]] <= acc >>> fpamu_pkg::XformShift;
         end
      end
   end

endmodule
